// File: src/two_point_rigid_transform_assert.svh
// assertion macros for the rigid transform block
`ifndef TWO_POINT_RIGID_TRANSFORM_ASSERT_SVH
`define TWO_POINT_RIGID_TRANSFORM_ASSERT_SVH
// property that must hold at every clock edge out of reset
`define TPRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked in the cycle after its trigger
`define TPRT_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`endif

// File: src/tprt_pkg.sv
// shared constants and the arctangent table for the rigid transform block
package tprt_pkg;
  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned CordicStages = 24;
  localparam int unsigned AngW         = 32;
  localparam int unsigned TrigW        = 32;
  localparam logic signed [TrigW-1:0] OneQ30  = 32'sd1073741824;
  localparam logic signed [TrigW-1:0] InvGain = 32'sd652032874;

  function automatic logic [AngW-1:0] atan_lut(input int unsigned i);
    logic [AngW-1:0] r;
    r = '0;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// File: src/tprt_if.sv
// valid/ready channel carrying one word of payload
interface tprt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/tprt_vec.sv
// pipelined vectoring cordic for two vectors, gives angle difference
module tprt_vec import tprt_pkg::*; #(
  parameter int unsigned CW = CoordWidth,
  parameter int unsigned NS = CordicStages
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [CW:0]  cx_i,
  input  logic signed [CW:0]  cy_i,
  input  logic signed [CW:0]  ox_i,
  input  logic signed [CW:0]  oy_i,
  output logic [AngW-1:0]     theta_o
);
  localparam int unsigned VW = CW + 4;
  logic signed [VW-1:0] cx_q [NS+1];
  logic signed [VW-1:0] cy_q [NS+1];
  logic signed [VW-1:0] ox_q [NS+1];
  logic signed [VW-1:0] oy_q [NS+1];
  logic [AngW-1:0] cz_q [NS+1];
  logic [AngW-1:0] oz_q [NS+1];
  logic signed [VW-1:0] cx0, cy0, ox0, oy0;

  always_comb begin
    cx0 = VW'(cx_i);
    cy0 = VW'(cy_i);
    ox0 = VW'(ox_i);
    oy0 = VW'(oy_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= cx0[VW-1] ? -cx0 : cx0;
      cy_q[0] <= cx0[VW-1] ? -cy0 : cy0;
      cz_q[0] <= cx0[VW-1] ? 32'h80000000 : '0;
      ox_q[0] <= ox0[VW-1] ? -ox0 : ox0;
      oy_q[0] <= ox0[VW-1] ? -oy0 : oy0;
      oz_q[0] <= ox0[VW-1] ? 32'h80000000 : '0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_st
    localparam logic [AngW-1:0] At = atan_lut(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_q[i][VW-1]) begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + At;
        end else begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - At;
        end
        if (!oy_q[i][VW-1]) begin
          ox_q[i+1] <= ox_q[i] + (oy_q[i] >>> i);
          oy_q[i+1] <= oy_q[i] - (ox_q[i] >>> i);
          oz_q[i+1] <= oz_q[i] + At;
        end else begin
          ox_q[i+1] <= ox_q[i] - (oy_q[i] >>> i);
          oy_q[i+1] <= oy_q[i] + (ox_q[i] >>> i);
          oz_q[i+1] <= oz_q[i] - At;
        end
      end
    end
  end

  assign theta_o = cz_q[NS] - oz_q[NS];
endmodule

// File: src/tprt_rot.sv
// pipelined rotation cordic giving cos and sin in q1.30
module tprt_rot import tprt_pkg::*; #(
  parameter int unsigned NS = CordicStages
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [AngW-1:0]         theta_i,
  input  logic                    degen_i,
  output logic signed [TrigW-1:0] cos_o,
  output logic signed [TrigW-1:0] sin_o
);
  localparam int unsigned RW = 34;
  logic signed [RW-1:0] x_q [NS+1];
  logic signed [RW-1:0] y_q [NS+1];
  logic [AngW-1:0] z_q [NS+1];
  logic [NS:0] flip_q, degen_q;
  logic [AngW-1:0] sum;
  logic signed [RW-1:0] xf, yf;

  assign sum = theta_i + 32'h40000000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]     <= RW'(InvGain);
      y_q[0]     <= '0;
      z_q[0]     <= sum[AngW-1] ? theta_i - 32'h80000000 : theta_i;
      flip_q[0]  <= sum[AngW-1];
      degen_q[0] <= degen_i;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_st
    localparam logic [AngW-1:0] At = atan_lut(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][AngW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - At;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + At;
        end
        flip_q[i+1]  <= flip_q[i];
        degen_q[i+1] <= degen_q[i];
      end
    end
  end

  always_comb begin
    xf = flip_q[NS] ? -x_q[NS] : x_q[NS];
    yf = flip_q[NS] ? -y_q[NS] : y_q[NS];
    if (xf > RW'(OneQ30)) xf = RW'(OneQ30);
    else if (xf < -RW'(OneQ30)) xf = -RW'(OneQ30);
    if (yf > RW'(OneQ30)) yf = RW'(OneQ30);
    else if (yf < -RW'(OneQ30)) yf = -RW'(OneQ30);
    if (degen_q[NS]) begin
      xf = RW'(OneQ30);
      yf = '0;
    end
    cos_o = TrigW'(xf);
    sin_o = TrigW'(yf);
  end
endmodule

// File: src/tprt_xform.sv
// products, sums, rounding and saturation of translation and query point
module tprt_xform import tprt_pkg::*; #(
  parameter int unsigned CW = CoordWidth
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [TrigW-1:0] cos_i,
  input  logic signed [TrigW-1:0] sin_i,
  input  logic signed [CW-1:0]    oax_i,
  input  logic signed [CW-1:0]    oay_i,
  input  logic signed [CW-1:0]    cax_i,
  input  logic signed [CW-1:0]    cay_i,
  input  logic signed [CW-1:0]    qx_i,
  input  logic signed [CW-1:0]    qy_i,
  output logic signed [CW-1:0]    tx_o,
  output logic signed [CW-1:0]    ty_o,
  output logic signed [CW-1:0]    ox_o,
  output logic signed [CW-1:0]    oy_o,
  output logic signed [TrigW-1:0] cos_o,
  output logic signed [TrigW-1:0] sin_o
);
  localparam int unsigned PW = TrigW + CW;
  localparam int unsigned SW = PW + 4;
  logic signed [PW-1:0] p_q [8];
  logic signed [CW-1:0] cax_q, cay_q;
  logic signed [TrigW-1:0] c1_q, s1_q, c2_q, s2_q;
  logic signed [SW-1:0] tx_q, ty_q, qrx_q, qry_q;
  logic signed [SW-1:0] ox_q, oy_q, tx2_q, ty2_q;
  logic signed [SW-1:0] half;

  assign half = SW'(1) <<< 29;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= PW'(cos_i) * PW'(oax_i);
      p_q[1] <= PW'(sin_i) * PW'(oay_i);
      p_q[2] <= PW'(sin_i) * PW'(oax_i);
      p_q[3] <= PW'(cos_i) * PW'(oay_i);
      p_q[4] <= PW'(cos_i) * PW'(qx_i);
      p_q[5] <= PW'(sin_i) * PW'(qy_i);
      p_q[6] <= PW'(sin_i) * PW'(qx_i);
      p_q[7] <= PW'(cos_i) * PW'(qy_i);
      cax_q  <= cax_i;
      cay_q  <= cay_i;
      c1_q   <= cos_i;
      s1_q   <= sin_i;
      tx_q   <= (SW'(cax_q) <<< 30) - SW'(p_q[0]) + SW'(p_q[1]);
      ty_q   <= (SW'(cay_q) <<< 30) - SW'(p_q[2]) - SW'(p_q[3]);
      qrx_q  <= SW'(p_q[4]) - SW'(p_q[5]);
      qry_q  <= SW'(p_q[6]) + SW'(p_q[7]);
      c2_q   <= c1_q;
      s2_q   <= s1_q;
      ox_q   <= (qrx_q + tx_q + half) >>> 30;
      oy_q   <= (qry_q + ty_q + half) >>> 30;
      tx2_q  <= (tx_q + half) >>> 30;
      ty2_q  <= (ty_q + half) >>> 30;
      cos_o  <= c2_q;
      sin_o  <= s2_q;
    end
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] mx, mn;
    mx = SW'({1'b0, {(CW-1){1'b1}}});
    mn = -mx - SW'(1);
    if (v > mx) return CW'(mx);
    if (v < mn) return CW'(mn);
    return CW'(v);
  endfunction

  assign tx_o = sat(tx2_q);
  assign ty_o = sat(ty2_q);
  assign ox_o = sat(ox_q);
  assign oy_o = sat(oy_q);
endmodule

// File: src/two_point_rigid_transform.sv
// Two-point rigid transform: one word in and one word out every cycle while the output is
// not stalled. A word passes through the vectoring and
// rotation CORDIC chains of CORDIC_STAGES+1 stages each, then three stages of products, sums
// and rounding. A stall freezes the whole pipeline; the last stage holds the waiting word.
module two_point_rigid_transform import tprt_pkg::*; #(
  parameter int unsigned COORD_WIDTH   = CoordWidth,
  parameter int unsigned CORDIC_STAGES = CordicStages
) (
  input  logic clk_i,
  input  logic rst_ni,
  tprt_if.sink   in_i,
  tprt_if.source out_o
);
  localparam int unsigned Lat = 2 * CORDIC_STAGES + 5;
  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned Dly = 2 * CORDIC_STAGES + 2;

  logic [Lat-1:0] vld_q;
  logic en;
  logic signed [CW:0] cdx, cdy, odx, ody;
  logic [AngW-1:0] theta;
  logic signed [TrigW-1:0] co, si, co_o, si_o;
  logic signed [CW-1:0] tx, ty, ox, oy;
  logic signed [CW-1:0] d_q [Dly][6];
  logic [CORDIC_STAGES:0] dg_q;

  assign en = !vld_q[Lat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  assign odx = (CW+1)'(in_i.data.orig_b_x) - (CW+1)'(in_i.data.orig_a_x);
  assign ody = (CW+1)'(in_i.data.orig_b_y) - (CW+1)'(in_i.data.orig_a_y);
  assign cdx = (CW+1)'(in_i.data.cur_b_x) - (CW+1)'(in_i.data.cur_a_x);
  assign cdy = (CW+1)'(in_i.data.cur_b_y) - (CW+1)'(in_i.data.cur_a_y);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0][0] <= in_i.data.orig_a_x;
      d_q[0][1] <= in_i.data.orig_a_y;
      d_q[0][2] <= in_i.data.cur_a_x;
      d_q[0][3] <= in_i.data.cur_a_y;
      d_q[0][4] <= in_i.data.query_x;
      d_q[0][5] <= in_i.data.query_y;
      dg_q[0]   <= (odx == '0 && ody == '0) || (cdx == '0 && cdy == '0);
      for (int i = 1; i < Dly; i++) d_q[i] <= d_q[i-1];
      for (int i = 1; i <= CORDIC_STAGES; i++) dg_q[i] <= dg_q[i-1];
    end
  end

  tprt_vec #(.CW(CW), .NS(CORDIC_STAGES)) u_vec (
    .clk_i, .en_i(en), .cx_i(cdx), .cy_i(cdy), .ox_i(odx), .oy_i(ody),
    .theta_o(theta)
  );

  tprt_rot #(.NS(CORDIC_STAGES)) u_rot (
    .clk_i, .en_i(en), .theta_i(theta), .degen_i(dg_q[CORDIC_STAGES]),
    .cos_o(co), .sin_o(si)
  );

  tprt_xform #(.CW(CW)) u_xf (
    .clk_i, .en_i(en), .cos_i(co), .sin_i(si),
    .oax_i(d_q[Dly-1][0]), .oay_i(d_q[Dly-1][1]),
    .cax_i(d_q[Dly-1][2]), .cay_i(d_q[Dly-1][3]),
    .qx_i(d_q[Dly-1][4]), .qy_i(d_q[Dly-1][5]),
    .tx_o(tx), .ty_o(ty), .ox_o(ox), .oy_o(oy), .cos_o(co_o), .sin_o(si_o)
  );

  assign out_o.valid          = vld_q[Lat-1];
  assign out_o.data.cos_theta = co_o;
  assign out_o.data.sin_theta = si_o;
  assign out_o.data.trans_x   = tx;
  assign out_o.data.trans_y   = ty;
  assign out_o.data.out_x     = ox;
  assign out_o.data.out_y     = oy;
endmodule

// File: src/tprt_checker.sv
// port-level checks for the rigid transform block
`include "two_point_rigid_transform_assert.svh"
module tprt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic signed [31:0] cos_i,
  input logic signed [31:0] sin_i
);
  `TPRT_ASSERT(a_ready_free, clk_i, rst_ni, !out_valid_i || out_ready_i || !in_ready_i, "stalled word not back-pressured")
  `TPRT_ASSERT(a_ready_open, clk_i, rst_ni, out_valid_i || in_ready_i, "ready low with empty output")
  `TPRT_ASSERT(a_cos_rng, clk_i, rst_ni, !out_valid_i || (cos_i <= 32'sd1073741824 && cos_i >= -32'sd1073741824), "cos out of range")
  `TPRT_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(sin_i), "stalled word changed")
endmodule

bind two_point_rigid_transform tprt_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .cos_i(out_o.data.cos_theta), .sin_i(out_o.data.sin_theta)
);

// File: tb/sv/two_point_rigid_transform_tb.sv
// testbench for the two-point rigid transform: directed and random point sets vs a predictor
`timescale 1ns / 1ps
module two_point_rigid_transform_tb;
  import tprt_pkg::*;

  typedef struct packed {
    logic signed [31:0] orig_a_x, orig_a_y, orig_b_x, orig_b_y;
    logic signed [31:0] cur_a_x, cur_a_y, cur_b_x, cur_b_y;
    logic signed [31:0] query_x, query_y;
  } pose_in_t;

  typedef struct packed {
    logic signed [31:0] cos_theta, sin_theta, trans_x, trans_y, out_x, out_y;
  } pose_out_t;

  localparam logic [31:0] ArcTab [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] heading(longint x, longint y);
    logic [31:0] z;
    longint dx, dy;
    z = '0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < CordicStages; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ArcTab[i];
      end else begin
        x -= dx; y += dy; z -= ArcTab[i];
      end
    end
    return z;
  endfunction

  function automatic void rotor(logic [31:0] theta, output longint co, output longint si);
    longint x, y, dx, dy;
    logic [31:0] z, t;
    logic flip;
    t = theta + 32'h40000000;
    flip = t[31];
    z = flip ? theta - 32'h80000000 : theta;
    x = 652032874; y = 0;
    for (int i = 0; i < CordicStages; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (!z[31]) begin
        x -= dx; y += dy; z -= ArcTab[i];
      end else begin
        x += dx; y -= dy; z += ArcTab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    co = clip(x, -64'sd1073741824, 64'sd1073741824);
    si = clip(y, -64'sd1073741824, 64'sd1073741824);
  endfunction

  function automatic void mac(longint k, longint v, ref longint hi, ref longint lo);
    longint p;
    p = k * (v & 64'h3FFFFFFF);
    hi += k * (v >>> 30) + (p >>> 30);
    lo += p & 64'h3FFFFFFF;
  endfunction

  function automatic longint round_sat(longint hi, longint lo);
    return clip(hi + ((lo + 64'sd536870912) >>> 30), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic pose_out_t transform_pose(pose_in_t w);
    pose_out_t r;
    longint co, si, hi, lo, odx, ody, cdx, cdy;
    odx = longint'(w.orig_b_x) - w.orig_a_x; ody = longint'(w.orig_b_y) - w.orig_a_y;
    cdx = longint'(w.cur_b_x) - w.cur_a_x;   cdy = longint'(w.cur_b_y) - w.cur_a_y;
    co = 64'sd1073741824; si = 0;
    if ((odx != 0 || ody != 0) && (cdx != 0 || cdy != 0))
      rotor(heading(cdx, cdy) - heading(odx, ody), co, si);
    r.cos_theta = co[31:0];
    r.sin_theta = si[31:0];
    hi = w.cur_a_x; lo = 0;
    mac(-co, w.orig_a_x, hi, lo); mac(si, w.orig_a_y, hi, lo);
    r.trans_x = 32'(round_sat(hi, lo));
    mac(co, w.query_x, hi, lo); mac(-si, w.query_y, hi, lo);
    r.out_x = 32'(round_sat(hi, lo));
    hi = w.cur_a_y; lo = 0;
    mac(-si, w.orig_a_x, hi, lo); mac(-co, w.orig_a_y, hi, lo);
    r.trans_y = 32'(round_sat(hi, lo));
    mac(si, w.query_x, hi, lo); mac(co, w.query_y, hi, lo);
    r.out_y = 32'(round_sat(hi, lo));
    return r;
  endfunction

  class pose_scoreboard;
    pose_out_t pending_poses[$];
    int        mismatches, checked, accepted;

    function void note_input(pose_in_t w);
      pending_poses.insert(pending_poses.size(), transform_pose(w));
      accepted++;
    endfunction

    function void check_result(pose_out_t got);
      pose_out_t exp_w;
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      exp_w = pending_poses.pop_front();
      checked++;
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %0d: cos %h/%h sin %h/%h tx %h/%h ty %h/%h ox %h/%h oy %h/%h",
            checked, exp_w.cos_theta, got.cos_theta, exp_w.sin_theta, got.sin_theta,
            exp_w.trans_x, got.trans_x, exp_w.trans_y, got.trans_y,
            exp_w.out_x, got.out_x, exp_w.out_y, got.out_y);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  int   idle_pct, stall_pct;
  pose_scoreboard sb;

  tprt_if #(.T(pose_in_t))  pose_in ();
  tprt_if #(.T(pose_out_t)) pose_out ();

  two_point_rigid_transform DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pose_in.sink),
    .out_o (pose_out.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && pose_in.valid && pose_in.ready) sb.note_input(pose_in.data);
    if (rst_ni && pose_out.valid && pose_out.ready) sb.check_result(pose_out.data);
  end

  initial begin
    pose_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      pose_out.ready <= $urandom_range(99) >= stall_pct;
    end
  end

  task automatic send_word(pose_in_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      pose_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pose_in.valid <= 1'b1;
    pose_in.data  <= w;
    do @(posedge clk_i); while (!pose_in.ready);
  endtask

  function automatic logic [31:0] pick_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(32'h00200000) - 32'h00100000;
      default: begin
        case ($urandom_range(5))
          0: return 32'h80000000;
          1: return 32'h7FFFFFFF;
          2: return 32'h0;
          3: return 32'hFFFFFFFF;
          4: return 32'h00010000;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic pose_in_t random_pose();
    pose_in_t w;
    int mode;
    mode = $urandom_range(3);
    w = {pick_coord(mode), pick_coord(mode), pick_coord(mode), pick_coord(mode),
         pick_coord(mode), pick_coord(mode), pick_coord(mode), pick_coord(mode),
         pick_coord(mode), pick_coord(mode)};
    case ($urandom_range(9))
      0: begin w.orig_b_x = w.orig_a_x; w.orig_b_y = w.orig_a_y; end
      1: begin w.cur_b_x = w.cur_a_x; w.cur_b_y = w.cur_a_y; end
      default: ;
    endcase
    return w;
  endfunction

  pose_in_t w;
  int wait_cycles;

  initial begin
    sb = new();
    idle_pct = 0; stall_pct = 0;
    rst_ni = 1'b0;
    pose_in.valid = 1'b0;
    pose_in.data  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // extremes, degenerate pairs and each quadrant of rotation
    send_word('0);
    send_word({10{32'h7FFFFFFF}});
    send_word({10{32'h80000000}});
    send_word({10{32'hFFFFFFFF}});
    send_word({32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0,
               32'h00020000, 32'h00030000});
    send_word({32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000,
               32'h00020000, 32'h00030000});
    send_word({32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'hFFFF0000, 32'h0,
               32'h00020000, 32'h00030000});
    send_word({32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF0000,
               32'h00020000, 32'h00030000});
    send_word({32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'hFFFF0000, 32'h00000001,
               32'h0, 32'h0});
    send_word({32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'hFFFF0000, 32'hFFFFFFFF,
               32'h0, 32'h0});
    send_word({32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
               32'h7FFFFFFF, 32'h80000000});
    send_word({32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h0, 32'h80000000, 32'h0,
               32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF});
    send_word({32'h00050000, 32'h00050000, 32'h00050000, 32'h00050000,
               32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6});
    send_word({32'h1, 32'h2, 32'h3, 32'h4,
               32'h00050000, 32'h00050000, 32'h00050000, 32'h00050000, 32'h5, 32'h6});
    send_word({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
               32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
               32'h7FFFFFFF, 32'h7FFFFFFF});

    // hold off until the pipeline has drained
    @(negedge clk_i) pose_in.valid <= 1'b0;
    while (sb.pending_poses.size() != 0) @(posedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < 135; n++) begin
        w = random_pose();
        send_word(w);
      end
    end
    @(negedge clk_i) pose_in.valid <= 1'b0;
    idle_pct = 0; stall_pct = 0;

    wait_cycles = 0;
    while (sb.pending_poses.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (80) @(posedge clk_i);

    $display("covered %0d point sets (%0d results checked) across four handshake phases",
             sb.accepted, sb.checked);
    $display("mismatches: %0d, results left over: %0d", sb.mismatches,
             sb.pending_poses.size());
    if (sb.mismatches == 0 && sb.pending_poses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
